// ===== design/rrrm_pkg.sv =====
`default_nettype none
package rrrm_pkg;

  localparam int ID_W  = 64;
  localparam int CL_W  = 16;
  localparam int BE_W  = 3;
  localparam int CNT_W = 4;
  localparam int CFG_W = 2;

  localparam logic [2:0] ST_FORWARDED  = 3'd0;
  localparam logic [2:0] ST_NO_BACKEND = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_MATCHED    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;
  localparam logic [2:0] ST_LINK       = 3'd5;

  localparam logic [CFG_W-1:0] CFG_BACKEND_COUNT = 2'd0;
  localparam logic [CFG_W-1:0] CFG_START_BACKEND = 2'd1;

  localparam logic [1:0] OP_LINK     = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;
  localparam logic [1:0] OP_RESPONSE = 2'd2;

  typedef enum logic [1:0] {
    K_LINK,
    K_REQ,
    K_RSP,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              bad_idx;
    logic [BE_W-1:0]   be;
    logic              up;
    logic [ID_W-1:0]   id;
    logic [CL_W-1:0]   client;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BE_W-1:0]   be;
    logic [ID_W-1:0]   id;
    logic [CL_W-1:0]   client;
  } res_t;

  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   new_id;
    logic [ID_W-1:0]   orig_id;
    logic [CL_W-1:0]   client;
  } ent_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MOD,
    S_TRY,
    S_RD,
    S_CHK
  } state_t;

endpackage
`default_nettype wire

// ===== design/rrrm_ram.sv =====
`default_nettype none
module rrrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/rrrm_front.sv =====
`default_nettype none
module rrrm_front #(
  parameter int MAX_BACKENDS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_op,
  input  wire logic [rrrm_pkg::BE_W-1:0]  in_backend_index,
  input  wire logic                       in_link_up,
  input  wire logic [rrrm_pkg::ID_W-1:0]  in_message_id,
  input  wire logic [rrrm_pkg::CL_W-1:0]  in_client_handle,
  output logic                            cmd_valid,
  output rrrm_pkg::cmd_t                  cmd,
  input  wire logic                       cmd_pop
);

  rrrm_pkg::cmd_t q_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           acc;
  rrrm_pkg::cmd_t cls;

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign acc       = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    case (in_op)
      rrrm_pkg::OP_LINK:     cls.kind = rrrm_pkg::K_LINK;
      rrrm_pkg::OP_REQUEST:  cls.kind = rrrm_pkg::K_REQ;
      rrrm_pkg::OP_RESPONSE: cls.kind = rrrm_pkg::K_RSP;
      default:               cls.kind = rrrm_pkg::K_BAD;
    endcase
    cls.bad_idx = (32'(in_backend_index) >= MAX_BACKENDS);
    cls.be      = in_backend_index;
    cls.up      = in_link_up;
    cls.id      = in_message_id;
    cls.client  = in_client_handle;
  end

  always_comb begin
    wp_nxt  = acc ? ~wp_r : wp_r;
    rp_nxt  = (cmd_pop && cmd_valid) ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, acc} - {1'b0, cmd_pop && cmd_valid});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/rrrm_back.sv =====
`default_nettype none
module rrrm_back #(
  parameter int MAX_BACKENDS        = 8,
  parameter int ENTRIES_PER_BACKEND = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  output logic                             clearing,
  input  wire logic                        cmd_valid,
  input  wire rrrm_pkg::cmd_t              cmd,
  output logic                             cmd_pop,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rrrm_pkg::CFG_W-1:0]  cfg_index,
  input  wire logic [rrrm_pkg::CNT_W-1:0]  cfg_data,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output rrrm_pkg::res_t                   res
);

  localparam int BW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int KW = (ENTRIES_PER_BACKEND > 1) ? $clog2(ENTRIES_PER_BACKEND) : 1;
  localparam int AW = BW + KW;
  localparam int EW = $bits(rrrm_pkg::ent_t);
  localparam int CW = rrrm_pkg::CNT_W;

  rrrm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [MAX_BACKENDS-1:0] up_r, up_nxt;
  rrrm_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;

  rrrm_pkg::res_t   oq_r [2];
  logic             oq_wp_r, oq_rp_r;
  logic [1:0]       oq_cnt_r;
  logic             emit;
  rrrm_pkg::res_t   emit_res;

  logic                      ent_we;
  logic [AW-1:0]             ent_waddr;
  logic [EW-1:0]             ent_wdata;
  logic [EW-1:0]             ent_rdata;
  logic                      cnt_we;
  logic [BW-1:0]             cnt_waddr;
  logic [rrrm_pkg::ID_W-1:0] cnt_wdata;
  logic [rrrm_pkg::ID_W-1:0] cnt_rdata;

  logic [CW-1:0]             n;
  logic                      take;
  logic                      cur_up;
  logic                      try_last;
  logic                      k_last;
  logic                      chk_done;
  rrrm_pkg::ent_t            e;
  rrrm_pkg::ent_t            e_new;
  logic [rrrm_pkg::ID_W-1:0] nid;

  rrrm_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_ent (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr ({b_r, k_r}),
    .rdata (ent_rdata)
  );

  rrrm_ram #(.WIDTH(rrrm_pkg::ID_W), .DEPTH(2 ** BW)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (b_r),
    .rdata (cnt_rdata)
  );

  assign n         = (32'(count_r) > MAX_BACKENDS) ? CW'(MAX_BACKENDS) : count_r;
  assign take      = cmd_valid && (oq_cnt_r != 2'd2);
  assign cur_up    = up_r[BW'(ptr_r)];
  assign try_last  = (i_r == CW'(n - 1'b1));
  assign k_last    = (k_r == KW'(ENTRIES_PER_BACKEND - 1));
  assign e         = rrrm_pkg::ent_t'(ent_rdata);
  assign nid       = cnt_rdata + 1'b1;
  assign clearing  = (state_r == rrrm_pkg::S_CLR);
  assign cfg_ready = 1'b1;
  assign out_empty = (oq_cnt_r == 2'd0);
  assign res       = oq_r[oq_rp_r];

  always_comb begin
    if (cmd_r.kind == rrrm_pkg::K_REQ) begin
      chk_done = !e.vld || k_last;
    end else begin
      chk_done = (e.vld && (e.new_id == cmd_r.id)) || k_last;
    end
  end

  always_comb begin
    e_new.vld     = 1'b1;
    e_new.new_id  = nid;
    e_new.orig_id = cmd_r.id;
    e_new.client  = cmd_r.client;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrrm_pkg::S_CLR: begin
        if (&clr_r) begin
          state_nxt = rrrm_pkg::S_IDLE;
        end
      end
      rrrm_pkg::S_IDLE: begin
        if (take) begin
          if (cmd.kind == rrrm_pkg::K_REQ && n != '0) begin
            state_nxt = rrrm_pkg::S_MOD;
          end else if (cmd.kind == rrrm_pkg::K_RSP && !cmd.bad_idx) begin
            state_nxt = rrrm_pkg::S_RD;
          end
        end
      end
      rrrm_pkg::S_MOD: begin
        if (ptr_r < n) begin
          state_nxt = rrrm_pkg::S_TRY;
        end
      end
      rrrm_pkg::S_TRY: begin
        if (cur_up) begin
          state_nxt = rrrm_pkg::S_RD;
        end else if (try_last) begin
          state_nxt = rrrm_pkg::S_IDLE;
        end
      end
      rrrm_pkg::S_RD: state_nxt = rrrm_pkg::S_CHK;
      rrrm_pkg::S_CHK: begin
        state_nxt = chk_done ? rrrm_pkg::S_IDLE : rrrm_pkg::S_RD;
      end
      default: state_nxt = rrrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    i_nxt     = i_r;
    up_nxt    = up_r;
    cmd_nxt   = cmd_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    ent_we    = 1'b0;
    ent_waddr = {b_r, k_r};
    ent_wdata = '0;
    cnt_we    = 1'b0;
    cnt_waddr = b_r;
    cnt_wdata = nid;
    case (state_r)
      rrrm_pkg::S_CLR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        cnt_we    = (clr_r[AW-1:BW] == '0);
        cnt_waddr = clr_r[BW-1:0];
        cnt_wdata = '0;
        clr_nxt   = AW'(clr_r + 1'b1);
      end
      rrrm_pkg::S_IDLE: begin
        if (take) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          b_nxt   = BW'(cmd.be);
          k_nxt   = '0;
          i_nxt   = '0;
          case (cmd.kind)
            rrrm_pkg::K_LINK: begin
              if (!cmd.bad_idx) begin
                up_nxt[BW'(cmd.be)] = cmd.up;
              end
              emit            = 1'b1;
              emit_res.status = rrrm_pkg::ST_LINK;
              emit_res.be     = cmd.be;
            end
            rrrm_pkg::K_REQ: begin
              if (n == '0) begin
                emit            = 1'b1;
                emit_res.status = rrrm_pkg::ST_NO_BACKEND;
              end
            end
            rrrm_pkg::K_RSP: begin
              if (cmd.bad_idx) begin
                emit            = 1'b1;
                emit_res.status = rrrm_pkg::ST_UNKNOWN;
                emit_res.be     = cmd.be;
              end
            end
            default: begin
              emit            = 1'b1;
              emit_res.status = rrrm_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      rrrm_pkg::S_MOD: begin
        if (ptr_r >= n) begin
          ptr_nxt = CW'(ptr_r - n);
        end
      end
      rrrm_pkg::S_TRY: begin
        b_nxt   = BW'(ptr_r);
        k_nxt   = '0;
        ptr_nxt = (CW'(ptr_r + 1'b1) == n) ? '0 : CW'(ptr_r + 1'b1);
        if (!cur_up) begin
          if (try_last) begin
            emit            = 1'b1;
            emit_res.status = rrrm_pkg::ST_NO_BACKEND;
          end else begin
            i_nxt = CW'(i_r + 1'b1);
          end
        end
      end
      rrrm_pkg::S_RD: begin
      end
      rrrm_pkg::S_CHK: begin
        if (!chk_done) begin
          k_nxt = KW'(k_r + 1'b1);
        end else if (cmd_r.kind == rrrm_pkg::K_REQ) begin
          emit        = 1'b1;
          emit_res.be = rrrm_pkg::BE_W'(b_r);
          if (!e.vld) begin
            ent_we          = 1'b1;
            ent_wdata       = e_new;
            cnt_we          = 1'b1;
            emit_res.status = rrrm_pkg::ST_FORWARDED;
            emit_res.id     = nid;
          end else begin
            emit_res.status = rrrm_pkg::ST_TABLE_FULL;
          end
        end else begin
          emit        = 1'b1;
          emit_res.be = cmd_r.be;
          if (e.vld && (e.new_id == cmd_r.id)) begin
            ent_we          = 1'b1;
            emit_res.status = rrrm_pkg::ST_MATCHED;
            emit_res.id     = e.orig_id;
            emit_res.client = e.client;
          end else begin
            emit_res.status = rrrm_pkg::ST_UNKNOWN;
          end
        end
      end
      default: begin
      end
    endcase
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == rrrm_pkg::CFG_BACKEND_COUNT) begin
        count_nxt = cfg_data;
      end else if (cfg_index == rrrm_pkg::CFG_START_BACKEND) begin
        ptr_nxt = {1'b0, cfg_data[2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rrrm_pkg::S_CLR;
      clr_r    <= '0;
      count_r  <= CW'(1);
      ptr_r    <= '0;
      up_r     <= '0;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      up_r     <= up_nxt;
      oq_wp_r  <= emit ? ~oq_wp_r : oq_wp_r;
      oq_rp_r  <= (out_pop && !out_empty) ? ~oq_rp_r : oq_rp_r;
      oq_cnt_r <= 2'(oq_cnt_r + {1'b0, emit} - {1'b0, out_pop && !out_empty});
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    if (emit) begin
      oq_r[oq_wp_r] <= emit_res;
    end
  end

endmodule
`default_nettype wire

// ===== design/round_robin_request_id_remapper_unit.sv =====
// Link events, unused ops and out-of-range responses are answered from the idle state into the result queue.
// Requests: pointer reduction steps, then backends tried in turn, then a read and check per table slot (slot scan).
// Responses: a read and check per table slot, up to ENTRIES_PER_BACKEND slots.
// Throughput: one request at a time in the back end, a two-deep queue on each side.
// Reset: synchronous, active low; then a clearing pass over all 2**(BW+KW) entries (128 at defaults)
// over the entry table, with in_full held high; configuration writes are still taken.
`default_nettype none
module round_robin_request_id_remapper_unit #(
  parameter int MAX_BACKENDS        = 8,
  parameter int ENTRIES_PER_BACKEND = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [1:0]                 in_op,
  input  wire logic [rrrm_pkg::BE_W-1:0]  in_backend_index,
  input  wire logic                       in_link_up,
  input  wire logic [rrrm_pkg::ID_W-1:0]  in_message_id,
  input  wire logic [rrrm_pkg::CL_W-1:0]  in_client_handle,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [2:0]                      out_status,
  output logic [rrrm_pkg::BE_W-1:0]       out_chosen_backend,
  output logic [rrrm_pkg::ID_W-1:0]       out_out_id,
  output logic [rrrm_pkg::CL_W-1:0]       out_out_client,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [rrrm_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [rrrm_pkg::CNT_W-1:0] cfg_data
);

  logic           clearing;
  logic           cmd_valid;
  logic           cmd_pop;
  rrrm_pkg::cmd_t cmd;
  rrrm_pkg::res_t res;

  rrrm_front #(.MAX_BACKENDS(MAX_BACKENDS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .hold             (clearing),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_op            (in_op),
    .in_backend_index (in_backend_index),
    .in_link_up       (in_link_up),
    .in_message_id    (in_message_id),
    .in_client_handle (in_client_handle),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  rrrm_back #(
    .MAX_BACKENDS        (MAX_BACKENDS),
    .ENTRIES_PER_BACKEND (ENTRIES_PER_BACKEND)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_status         = res.status;
  assign out_chosen_backend = res.be;
  assign out_out_id         = res.id;
  assign out_out_client     = res.client;

endmodule
`default_nettype wire

// ===== design/rrrm_checker.sv =====
`default_nettype none
module rrrm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_full,
  input wire logic                      out_empty,
  input wire logic                      out_pop,
  input wire logic [2:0]                out_status,
  input wire logic [rrrm_pkg::BE_W-1:0] out_chosen_backend,
  input wire logic [rrrm_pkg::ID_W-1:0] out_out_id,
  input wire logic [rrrm_pkg::CL_W-1:0] out_out_client
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("requests taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_status) && $stable(out_chosen_backend)
      && $stable(out_out_id) && $stable(out_out_client)))
    else $error("waiting result changed");

  a_client: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != rrrm_pkg::ST_MATCHED) |-> (out_out_client == '0))
    else $error("client handle on unmatched result");

endmodule

bind round_robin_request_id_remapper_unit rrrm_checker u_chk (.*);
`default_nettype wire
